/* src/sle_pkg.sv */
// ----------------------------------------------------------------------------
// sle_pkg: shared codes for the sequential list engine
// Request codes, status codes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package sle_pkg;

  // request codes
  localparam logic [2:0] F_INSERT = 3'd0;
  localparam logic [2:0] F_DELETE = 3'd1;
  localparam logic [2:0] F_GET    = 3'd2;
  localparam logic [2:0] F_LOCATE = 3'd3;
  localparam logic [2:0] F_PRED   = 3'd4;
  localparam logic [2:0] F_SUCC   = 3'd5;
  localparam logic [2:0] F_CLEAR  = 3'd6;
  localparam logic [2:0] F_UNUSED = 3'd7;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_DRAIN,
    S_PUT,
    S_SCAN,
    S_RESP
  } state_t;

endpackage

`default_nettype wire

/* src/sle_ram.sv */
// ----------------------------------------------------------------------------
// sle_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* src/sle_key.sv */
// ----------------------------------------------------------------------------
// sle_key: search key register and shared compare unit
// Holds the key (optionally squared, wrapping) and compares one element.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_key (
  input  wire logic               clk,
  input  wire logic               load,
  input  wire logic               square,
  input  wire logic signed [31:0] operand,
  input  wire logic        [31:0] elem,
  output logic                    match
);

  logic [31:0] key;
  logic [31:0] key_next;

  // keep the low 32 bits of the product only
  always_comb begin
    key_next = square ? 32'(operand * operand) : operand;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      key <= key_next;
    end
  end

  assign match = (elem == key);

endmodule

`default_nettype wire

/* src/sequential_list_engine_core.sv */
// ----------------------------------------------------------------------------
// sequential_list_engine_core: fixed-capacity ordered list of 32-bit elements
// Insert, delete, get, locate, predecessor, successor and clear on a
// RAM-backed list, walked one entry per cycle by a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a request transfers at a rising edge with start high and
//   busy low (func, position, value, relation). busy stays high until the
//   result has been shown.
//   Result channel: done is high for exactly one cycle; status, result_value,
//   found_position, count and is_empty are valid in that cycle only. The
//   receiver cannot stall, so the result is dropped after that cycle.
//   Sequence: every request is checked first. Clear, the unused code, a bad
//   position, a full list, an empty list for locate and fewer than two
//   entries for predecessor/successor go straight to the result. Insert at
//   the tail writes the new entry and responds; otherwise insert moves the
//   entries up by one, drains and then writes. Delete and get read the
//   entries down and drain; locate scans; predecessor/successor scan and
//   then read the neighbor. Entries pass through the single RAM read port,
//   one entry per cycle; one request at a time.
//   Reset clears the length to zero; element storage is not cleared, since
//   only entries below the length are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module sequential_list_engine_core #(
  parameter int CAPACITY = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic        [2:0]  func,
  input  wire logic        [4:0]  position,
  input  wire logic signed [31:0] value,
  input  wire logic               relation,
  output logic                    done,
  output logic             [1:0]  status,
  output logic signed      [31:0] result_value,
  output logic             [4:0]  found_position,
  output logic             [4:0]  count,
  output logic                    is_empty
);

  import sle_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int CW = ((LW > 5) ? LW : 5) + 1;

  state_t state;
  state_t state_next;

  // request registers
  logic        [2:0]  func_r;
  logic        [4:0]  pos_r;
  logic signed [31:0] val_r;

  // list and walk state
  logic [LW-1:0] length;
  logic [IW-1:0] cursor;
  logic [IW-1:0] limit;
  logic [IW-1:0] tag;
  logic          pend;
  logic          pend_rv;
  logic          first;
  logic          scan_more;

  // result registers
  logic        [1:0]  status_r;
  logic signed [31:0] rv_r;
  logic        [4:0]  fp_r;

  // RAM and compare unit
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic [IW-1:0] rd_addr;
  logic [31:0]   rd_data;
  logic          match;
  logic          accept;

  // request checks
  logic [CW-1:0] p_ext;
  logic [CW-1:0] n_ext;
  logic [IW-1:0] pos_idx;
  logic          ins_bad;
  logic          is_full;
  logic          pos_bad;
  logic          at_tail;
  logic          few;
  logic          none;
  logic          at_limit;
  logic          hit;

  assign accept = start && !busy;

  always_comb begin
    p_ext    = CW'(pos_r);
    n_ext    = CW'(length);
    pos_idx  = IW'(p_ext - CW'(1));
    ins_bad  = (p_ext == '0) || (p_ext > n_ext + CW'(1));
    is_full  = (n_ext == CW'(CAPACITY));
    pos_bad  = (p_ext == '0) || (p_ext > n_ext);
    at_tail  = (p_ext == n_ext + CW'(1));
    few      = (n_ext < CW'(2));
    none     = (length == '0);
    at_limit = (cursor == limit);
    hit      = pend && match;
  end

  sle_ram #(
    .WIDTH (32),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // square the key only for locate with the squared rule
  sle_key u_key (
    .clk     (clk),
    .load    (accept),
    .square  (relation && (func == F_LOCATE)),
    .operand (value),
    .elem    (rd_data),
    .match   (match)
  );

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        case (func_r)
          F_INSERT: begin
            if (ins_bad || is_full) begin
              state_next = S_RESP;
            end else if (at_tail) begin
              state_next = S_PUT;
            end else begin
              state_next = S_SHIFT_UP;
            end
          end
          F_DELETE, F_GET: begin
            state_next = pos_bad ? S_RESP : S_SHIFT_DN;
          end
          F_LOCATE: begin
            state_next = none ? S_RESP : S_SCAN;
          end
          F_PRED, F_SUCC: begin
            state_next = few ? S_RESP : S_SCAN;
          end
          default: begin
            state_next = S_RESP;
          end
        endcase
      end
      S_SHIFT_UP, S_SHIFT_DN: begin
        if (at_limit) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = (func_r == F_INSERT) ? S_PUT : S_RESP;
      end
      S_PUT: begin
        state_next = S_RESP;
      end
      S_SCAN: begin
        if (hit) begin
          state_next = (func_r == F_LOCATE) ? S_RESP : S_SHIFT_DN;
        end else if (!scan_more) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // sequencer outputs: RAM port control and handshake
  always_comb begin
    busy    = 1'b1;
    done    = 1'b0;
    rd_addr = cursor;
    wr_en   = 1'b0;
    wr_addr = tag;
    wr_data = rd_data;
    case (state)
      S_IDLE: begin
        busy = 1'b0;
      end
      S_SHIFT_UP, S_SHIFT_DN, S_DRAIN: begin
        // retire the entry read last cycle into its new slot, except the returned element
        wr_en = pend && !pend_rv;
      end
      S_PUT: begin
        wr_en   = 1'b1;
        wr_addr = pos_idx;
        wr_data = val_r;
      end
      S_RESP: begin
        done = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      length    <= '0;
      pend      <= 1'b0;
      pend_rv   <= 1'b0;
      first     <= 1'b0;
      scan_more <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            func_r   <= func;
            pos_r    <= position;
            val_r    <= value;
            status_r <= ST_OK;
            rv_r     <= '0;
            fp_r     <= '0;
          end
        end
        S_CHECK: begin
          pend      <= 1'b0;
          pend_rv   <= 1'b0;
          first     <= 1'b1;
          scan_more <= 1'b1;
          case (func_r)
            F_INSERT: begin
              if (ins_bad) begin
                status_r <= ST_RANGE;
              end else if (is_full) begin
                status_r <= ST_FULL;
              end
              // move entries n-1 down to p-1 up by one
              cursor <= IW'(n_ext - CW'(1));
              limit  <= pos_idx;
            end
            F_DELETE: begin
              if (pos_bad) begin
                status_r <= ST_RANGE;
              end else begin
                length <= length - LW'(1);
              end
              cursor <= pos_idx;
              limit  <= IW'(n_ext - CW'(1));
            end
            F_GET: begin
              if (pos_bad) begin
                status_r <= ST_RANGE;
              end
              cursor <= pos_idx;
              limit  <= pos_idx;
            end
            F_LOCATE: begin
              if (none) begin
                status_r <= ST_NOTFOUND;
              end
              cursor <= '0;
              limit  <= IW'(n_ext - CW'(1));
            end
            F_PRED: begin
              // a match at the first entry has no predecessor
              if (few) begin
                status_r <= ST_NOTFOUND;
              end
              cursor <= IW'(1);
              limit  <= IW'(n_ext - CW'(1));
            end
            F_SUCC: begin
              // a match at the last entry has no successor
              if (few) begin
                status_r <= ST_NOTFOUND;
              end
              cursor <= '0;
              limit  <= IW'(n_ext - CW'(2));
            end
            F_CLEAR: begin
              length <= '0;
            end
            default: begin
              length <= length;
            end
          endcase
        end
        S_SHIFT_UP: begin
          tag     <= cursor + IW'(1);
          pend    <= 1'b1;
          pend_rv <= 1'b0;
          cursor  <= cursor - IW'(1);
        end
        S_SHIFT_DN: begin
          // the first entry read is the returned element
          if (pend && pend_rv) begin
            rv_r <= rd_data;
          end
          tag     <= cursor - IW'(1);
          pend    <= 1'b1;
          pend_rv <= first;
          first   <= 1'b0;
          cursor  <= cursor + IW'(1);
        end
        S_DRAIN: begin
          if (pend && pend_rv) begin
            rv_r <= rd_data;
          end
          pend <= 1'b0;
        end
        S_PUT: begin
          length <= length + LW'(1);
        end
        S_SCAN: begin
          if (hit) begin
            pend  <= 1'b0;
            first <= 1'b1;
            case (func_r)
              F_LOCATE: begin
                fp_r <= 5'(LW'(tag) + LW'(1));
              end
              F_PRED: begin
                cursor <= tag - IW'(1);
                limit  <= tag - IW'(1);
              end
              default: begin
                cursor <= tag + IW'(1);
                limit  <= tag + IW'(1);
              end
            endcase
          end else if (scan_more) begin
            tag  <= cursor;
            pend <= 1'b1;
            if (at_limit) begin
              scan_more <= 1'b0;
            end else begin
              cursor <= cursor + IW'(1);
            end
          end else begin
            status_r <= ST_NOTFOUND;
            pend     <= 1'b0;
          end
        end
        default: begin
          pend <= pend;
        end
      endcase
    end
  end

  assign status         = status_r;
  assign result_value   = rv_r;
  assign found_position = fp_r;
  assign count          = 5'(length);
  assign is_empty       = (length == '0);

  // ---------------- assertions ----------------
  a_accept_busy : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_done_single : assert property (@(posedge clk) disable iff (rst)
    done |=> (!done && !busy))
    else $error("result strobe not followed by idle");

  a_len_bound : assert property (@(posedge clk) disable iff (rst)
    length <= LW'(CAPACITY))
    else $error("list length beyond capacity");

  a_full_len : assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_FULL)) |-> (length == LW'(CAPACITY)))
    else $error("full status with list not full");

endmodule

`default_nettype wire
